/* sv/arta_pkg.sv */
// Shared constants, types and helper functions for the address range table allocator.
package arta_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int ADDR_W = 64;
  localparam int TYPE_W = 8;
  localparam int ALIGN_W = 32;
  localparam int ACT_W = 3;
  localparam int RIDX_W = 6;

  localparam int IN_W = ((2 * ADDR_W + TYPE_W + ALIGN_W + 7) / 8) * 8;
  localparam int OUT_W = ((2 + 2 * ADDR_W + RIDX_W + ADDR_W + TYPE_W + 7) / 8) * 8 - ADDR_W;

  localparam logic [TYPE_W-1:0] T_READ = 8'h01;
  localparam logic [TYPE_W-1:0] T_WRITE = 8'h02;
  localparam logic [TYPE_W-1:0] T_EXEC = 8'h04;
  localparam logic [TYPE_W-1:0] T_NOPAGE = 8'h08;
  localparam logic [TYPE_W-1:0] T_DISCARD = 8'h10;
  localparam logic [TYPE_W-1:0] T_SOLID = 8'h20;

  localparam logic [RIDX_W-1:0] RIDX_NONE = RIDX_W'(MAX_ENTRIES);

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_ALLOC  = 3'd2,
    ACT_PACK   = 3'd3,
    ACT_FIND   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_PROC,
    S_DIV,
    S_ALGN,
    S_EVAL,
    S_CMT,
    S_TAIL,
    S_W1,
    S_W2,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] start_addr;
  } entry_t;

  typedef struct packed {
    logic [ALIGN_W-1:0] alignment;
    logic [TYPE_W-1:0]  region_type;
    logic [ADDR_W-1:0]  region_size;
    logic [ADDR_W-1:0]  region_address;
  } in_t;

  typedef struct packed {
    logic [TYPE_W-1:0] found_type;
    logic [ADDR_W-1:0] region_end;
    logic [RIDX_W-1:0] region_index;
    logic [ADDR_W-1:0] result_address;
    logic              table_full;
    logic              ok;
  } out_t;

  function automatic logic type_fits(input logic [TYPE_W-1:0] req, input logic [TYPE_W-1:0] have);
    logic [TYPE_W-1:0] need;
    need = req & (T_READ | T_WRITE | T_EXEC | T_NOPAGE);
    return (req == '0) ||
           (((need & ~have) == '0) && ((req & T_DISCARD) == (have & T_DISCARD)));
  endfunction

  function automatic logic [TYPE_W-1:0] lead_type(input logic [TYPE_W-1:0] et);
    return ((et & T_SOLID) != '0) ? (et & ~T_EXEC) : et;
  endfunction

endpackage

/* sv/arta_rem.sv */
// Bit-serial remainder unit that reduces a 64-bit address modulo a 32-bit alignment.
module arta_rem import arta_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ADDR_W-1:0]  dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic               done,
  output logic [ALIGN_W-1:0] rem
);

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [ADDR_W-1:0] dvd;
  logic [ALIGN_W-1:0] dsr;
  logic [ALIGN_W:0]   trial;
  logic [ALIGN_W+1:0] diff;
  logic [ALIGN_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[ADDR_W-1]};
    diff = {1'b0, trial} - {2'b00, dsr};
    rem_next = diff[ALIGN_W+1] ? trial[ALIGN_W-1:0] : diff[ALIGN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

endmodule

/* sv/address_range_table_allocator_top.sv */
// Top level of the address range table allocator: table memory, sequencer and result register.
// Each transaction rewrites the table from one memory bank into the other, one entry at a time.
// In the copy pass each entry goes through the read, process and two write states in turn.
// An alloc with alignment above one runs the remainder unit for each candidate entry.
// An alloc that retries without the discardable bit makes a second full pass.
// Reset clears the entry count and the handshake state; the table memory is not cleared.
module address_range_table_allocator_top import arta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // region_address, region_size, region_type, alignment
  input  logic [IN_W-1:0]  s_tdata,
  // action
  input  logic [ACT_W-1:0] s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // ok, table_full, result_address, region_index, region_end, found_type
  output logic [OUT_W-1:0] m_tdata
);

  state_t state, state_next;

  entry_t mem [2*MAX_ENTRIES];
  entry_t q;
  logic   mem_we;
  entry_t mem_wd;

  logic             src;
  logic [CNT_W-1:0] count, n, rd_idx, wr_idx;

  action_t           act;
  in_t               req;
  in_t               sreq;
  logic [ADDR_W-1:0] rlim;
  logic [TYPE_W-1:0] tcur;
  logic              done, full, retry, tail;
  logic [ADDR_W-1:0] cur, tmp, avail;
  entry_t            ent, w1, w2, pend, fent;
  logic              w1v, w2v, pend_v, fhave;
  logic [CNT_W-1:0]  fk;

  logic [ADDR_W:0]   lim_sum;
  logic [ADDR_W-1:0] lim;
  logic [CNT_W:0]    occ;
  logic              room, align_on, alloc_cand, alg_skip, ev_fail, retry_go;
  logic              div_start, div_done, hit, a_ok;
  logic [ALIGN_W-1:0] rem;
  logic [ADDR_W-1:0]  tmp0;
  logic [ADDR_W:0]    alg_sum;
  out_t              res_o;

  assign sreq = in_t'(s_tdata);

  always_comb begin
    lim_sum = {1'b0, sreq.region_address} + {1'b0, sreq.region_size};
    lim = lim_sum[ADDR_W] ? '1 : lim_sum[ADDR_W-1:0];
    occ = {1'b0, wr_idx} + {1'b0, n} - {1'b0, rd_idx};
    room = occ < (CNT_W+1)'(MAX_ENTRIES);
    align_on = req.alignment > ALIGN_W'(1);
    alloc_cand = !done && ((req.region_address == '0) ||
                 ((q.start_addr <= req.region_address) && (req.region_address < q.end_addr)));
    tmp0 = (req.region_address != '0) ? req.region_address : q.start_addr;
    alg_sum = {1'b0, tmp} + (ADDR_W+1)'(req.alignment - rem);
    alg_skip = (rem != '0) && alg_sum[ADDR_W];
    ev_fail = (tmp > ent.end_addr) || (req.region_size > (ent.end_addr - tmp)) ||
              !type_fits(tcur, ent.etype);
    retry_go = (act == ACT_ALLOC) && !done && !retry &&
               ((req.region_type & T_DISCARD) != '0) && (req.region_address == '0);
    hit = (act == ACT_FIND) && fhave && (fent.end_addr > req.region_address);
    a_ok = (act == ACT_ALLOC) && done;
  end

  arta_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tmp0),
    .divisor  (req.alignment),
    .done     (div_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    q <= mem[{src, rd_idx[IDX_W-1:0]}];
    if (mem_we) begin
      mem[{~src, wr_idx[IDX_W-1:0]}] <= mem_wd;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_RD;
      S_RD:   state_next = (rd_idx == n) ? S_TAIL : S_PROC;
      S_PROC: begin
        if ((act == ACT_ALLOC) && alloc_cand) begin
          state_next = align_on ? S_DIV : S_EVAL;
        end else begin
          state_next = S_W1;
        end
      end
      S_DIV:  if (div_done) state_next = S_ALGN;
      S_ALGN: state_next = alg_skip ? S_W1 : S_EVAL;
      S_EVAL: state_next = ev_fail ? S_W1 : S_CMT;
      S_CMT:  state_next = S_W1;
      S_TAIL: state_next = S_W1;
      S_W1:   state_next = S_W2;
      S_W2:   state_next = tail ? S_FIN : S_RD;
      S_FIN:  state_next = retry_go ? S_RD : S_OUT;
      S_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    mem_we = ((state == S_W1) && w1v) || ((state == S_W2) && w2v);
    mem_wd = (state == S_W2) ? w2 : w1;
    div_start = (state == S_PROC) && (act == ACT_ALLOC) && alloc_cand && align_on;
  end

  always_comb begin
    res_o.ok = hit || a_ok;
    res_o.table_full = full;
    res_o.result_address = a_ok ? tmp : (hit ? fent.start_addr : '0);
    res_o.region_index = hit ? RIDX_W'(fk) : RIDX_NONE;
    res_o.region_end = hit ? fent.end_addr : '0;
    res_o.found_type = hit ? fent.etype : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      src <= 1'b0;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN) begin
        src <= ~src;
        count <= wr_idx;
      end
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_W'(res_o);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          act <= action_t'(s_tuser);
          req <= sreq;
          rlim <= lim;
          tcur <= sreq.region_type;
          cur <= sreq.region_address;
          rd_idx <= '0;
          wr_idx <= '0;
          n <= count;
          retry <= 1'b0;
          full <= 1'b0;
          tail <= 1'b0;
          pend_v <= 1'b0;
          fhave <= 1'b0;
          done <= ((s_tuser == ACT_ADD) || (s_tuser == ACT_REMOVE)) &&
                  (lim <= sreq.region_address);
        end
      end
      S_PROC: begin
        w1v <= 1'b0;
        w2v <= 1'b0;
        w1 <= q;
        w2 <= q;
        ent <= q;
        case (act)
          ACT_ADD: begin
            if (done || (q.end_addr <= cur)) begin
              w1v <= 1'b1;
            end else if (q.start_addr >= rlim) begin
              if (room) begin
                w1v <= 1'b1;
                w1 <= '{etype: tcur, end_addr: rlim, start_addr: cur};
              end else begin
                full <= 1'b1;
              end
              w2v <= 1'b1;
              done <= 1'b1;
            end else if (q.start_addr > cur) begin
              w2v <= 1'b1;
              if (room) begin
                w1v <= 1'b1;
                w1 <= '{etype: tcur, end_addr: q.start_addr, start_addr: cur};
                cur <= q.end_addr;
                done <= (q.end_addr >= rlim);
              end else begin
                full <= 1'b1;
                done <= 1'b1;
              end
            end else begin
              w1v <= 1'b1;
              cur <= q.end_addr;
              done <= (q.end_addr >= rlim);
            end
          end
          ACT_REMOVE: begin
            if (done) begin
              w1v <= 1'b1;
            end else if (q.start_addr >= rlim) begin
              w1v <= 1'b1;
              done <= 1'b1;
            end else if (q.start_addr < req.region_address) begin
              w1v <= 1'b1;
              if (q.end_addr > rlim) begin
                w1.end_addr <= req.region_address;
                w2 <= '{etype: q.etype, end_addr: q.end_addr, start_addr: rlim};
                if (room) begin
                  w2v <= 1'b1;
                end else begin
                  full <= 1'b1;
                end
                done <= 1'b1;
              end else if (q.end_addr > req.region_address) begin
                w1.end_addr <= req.region_address;
              end
            end else if (q.end_addr > rlim) begin
              w1v <= 1'b1;
              w1.start_addr <= rlim;
            end
          end
          ACT_ALLOC: begin
            if (alloc_cand) begin
              tmp <= tmp0;
            end else begin
              w1v <= 1'b1;
            end
          end
          ACT_PACK: begin
            if (pend_v && (pend.etype == q.etype) && (pend.end_addr == q.start_addr)) begin
              pend.end_addr <= q.end_addr;
            end else begin
              w1 <= pend;
              w1v <= pend_v;
              pend <= q;
              pend_v <= 1'b1;
            end
          end
          ACT_FIND: begin
            w1v <= 1'b1;
            if (!done) begin
              if (q.start_addr <= req.region_address) begin
                fhave <= 1'b1;
                fk <= rd_idx;
                fent <= q;
              end else begin
                done <= 1'b1;
              end
            end
          end
          default: w1v <= 1'b1;
        endcase
      end
      S_ALGN: begin
        if (alg_skip) begin
          w1 <= ent;
          w1v <= 1'b1;
        end else if (rem != '0) begin
          tmp <= alg_sum[ADDR_W-1:0];
        end
      end
      S_EVAL: begin
        avail <= ent.end_addr - tmp;
        if (ev_fail) begin
          w1 <= ent;
          w1v <= 1'b1;
        end
      end
      S_CMT: begin
        done <= 1'b1;
        if (ent.start_addr < tmp) begin
          if (room) begin
            w1v <= 1'b1;
            w1 <= '{etype: lead_type(ent.etype), end_addr: tmp, start_addr: ent.start_addr};
          end else begin
            full <= 1'b1;
          end
        end
        if (req.region_size != avail) begin
          w2v <= 1'b1;
          w2 <= '{etype: ent.etype, end_addr: ent.end_addr, start_addr: tmp + req.region_size};
        end
      end
      S_TAIL: begin
        tail <= 1'b1;
        w1v <= 1'b0;
        w2v <= 1'b0;
        case (act)
          ACT_ADD: begin
            if (!done) begin
              if (room) begin
                w1v <= 1'b1;
                w1 <= '{etype: tcur, end_addr: rlim, start_addr: cur};
              end else begin
                full <= 1'b1;
              end
            end
          end
          ACT_PACK: begin
            w1 <= pend;
            w1v <= pend_v;
          end
          default: w1v <= 1'b0;
        endcase
      end
      S_W1: begin
        if (w1v) wr_idx <= wr_idx + 1'b1;
      end
      S_W2: begin
        if (w2v) wr_idx <= wr_idx + 1'b1;
        if (!tail) rd_idx <= rd_idx + 1'b1;
      end
      S_FIN: begin
        if (retry_go) begin
          retry <= 1'b1;
          tcur <= tcur & ~T_DISCARD;
          rd_idx <= '0;
          wr_idx <= '0;
          tail <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/arta_chk.sv */
// Port-level checker for the address range table allocator, bound to the top level.
module arta_chk import arta_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  out_t res;
  assign res = out_t'(m_tdata);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result transaction changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while one is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.ok |-> (res.result_address == '0) && (res.region_index == RIDX_NONE) &&
                            (res.region_end == '0) && (res.found_type == '0))
    else $error("failed result carries nonzero data");

endmodule

bind address_range_table_allocator_top arta_chk u_arta_chk (.*);

/* bench/tb_address_range_table_allocator_top.sv */
// Self-checking testbench for the address range table allocator top level.
`timescale 1ns / 1ps

module tb_address_range_table_allocator_top;
  import arta_pkg::*;

  typedef struct {
    logic [ACT_W-1:0] act;
    in_t              d;
  } op_item_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [ACT_W-1:0] s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  address_range_table_allocator_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  op_item_t   pending_ops[$];
  out_t       expected_results[$];
  int         mismatches;
  int         results_seen;
  int         cycles;
  int         gap_left;
  int         burst_left;
  int         hold_left;
  bit         hold_done;
  int         ready_phase;
  bit         ready_mode;

  logic [ADDR_W-1:0] rng_lo[MAX_ENTRIES];
  logic [ADDR_W-1:0] rng_hi[MAX_ENTRIES];
  logic [TYPE_W-1:0] rng_ty[MAX_ENTRIES];
  int                rng_n;

  function automatic bit rng_insert(int at, logic [63:0] s, logic [63:0] e, logic [7:0] t);
    if (rng_n >= MAX_ENTRIES || at > rng_n) return 0;
    for (int j = rng_n; j > at; j--) begin
      rng_lo[j] = rng_lo[j-1];
      rng_hi[j] = rng_hi[j-1];
      rng_ty[j] = rng_ty[j-1];
    end
    rng_lo[at] = s;
    rng_hi[at] = e;
    rng_ty[at] = t;
    rng_n++;
    return 1;
  endfunction

  function automatic void rng_erase(int at);
    if (at >= rng_n) return;
    for (int j = at; j < rng_n - 1; j++) begin
      rng_lo[j] = rng_lo[j+1];
      rng_hi[j] = rng_hi[j+1];
      rng_ty[j] = rng_ty[j+1];
    end
    rng_n--;
  endfunction

  function automatic logic [63:0] sat_end(logic [63:0] a, logic [63:0] size);
    return (a > ~size) ? '1 : a + size;
  endfunction

  function automatic int lookup(logic [63:0] addr);
    int k;
    k = MAX_ENTRIES;
    for (int j = 0; j < rng_n; j++) begin
      if (rng_lo[j] <= addr) k = j;
      else break;
    end
    if (k < rng_n && rng_hi[k] > addr) return k;
    return MAX_ENTRIES;
  endfunction

  function automatic bit kind_ok(logic [7:0] req, logic [7:0] have);
    logic [7:0] need;
    need = req & 8'h0F;
    if (req == 0) return 1;
    if ((need & have) != need) return 0;
    return (req & T_DISCARD) == (have & T_DISCARD);
  endfunction

  function automatic bit add_range(logic [63:0] a, logic [63:0] size, logic [7:0] t);
    logic [63:0] cur;
    logic [63:0] e;
    int i;
    cur = a;
    e = sat_end(a, size);
    i = 0;
    while (cur < e) begin
      while (i < rng_n && rng_hi[i] <= cur) i++;
      if (i >= rng_n || rng_lo[i] >= e) return !rng_insert(i, cur, e, t);
      if (rng_lo[i] > cur) begin
        if (!rng_insert(i, cur, rng_lo[i], t)) return 1;
        i++;
      end
      cur = rng_hi[i];
      i++;
    end
    return 0;
  endfunction

  function automatic bit remove_range(logic [63:0] a, logic [63:0] size);
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] en;
    int i;
    bit full;
    e = sat_end(a, size);
    i = 0;
    full = 0;
    if (e <= a) return 0;
    while (i < rng_n) begin
      s = rng_lo[i];
      en = rng_hi[i];
      if (s >= e) break;
      if (s < a) begin
        if (en > e) begin
          if (!rng_insert(i + 1, e, en, rng_ty[i])) full = 1;
          rng_hi[i] = a;
          break;
        end
        if (en > a) rng_hi[i] = a;
        i++;
      end else begin
        rng_lo[i] = (en < e) ? en : e;
        if (rng_lo[i] == rng_hi[i]) rng_erase(i);
        else i++;
      end
    end
    return full;
  endfunction

  function automatic bit first_fit(logic [63:0] size, logic [7:0] t, logic [63:0] addr,
                                   logic [31:0] align, output logic [63:0] res,
                                   inout bit full);
    int lo;
    int hi;
    int i;
    logic [63:0] s;
    logic [63:0] tmp;
    logic [63:0] r;
    logic [63:0] add;
    logic [63:0] delta;
    logic [63:0] sz;
    logic [7:0] et;
    logic [7:0] pt;
    res = 0;
    if (addr != 0) begin
      lo = lookup(addr);
      if (lo >= rng_n) return 0;
      hi = lo + 1;
    end else begin
      lo = 0;
      hi = rng_n;
    end
    for (i = lo; i < hi && i < rng_n; i++) begin
      s = rng_lo[i];
      tmp = (addr != 0) ? addr : s;
      if (align > 1) begin
        r = tmp % {32'd0, align};
        if (r != 0) begin
          add = {32'd0, align} - r;
          if (tmp > ~add) continue;
          tmp += add;
        end
      end
      if (s < tmp) begin
        delta = tmp - s;
        sz = rng_hi[i] - s;
        et = rng_ty[i];
        if (delta > sz || size > sz - delta) continue;
        if (!kind_ok(t, et)) continue;
        pt = ((et & T_SOLID) != 0) ? (et & ~T_EXEC) : et;
        rng_lo[i] = tmp;
        if (rng_insert(i, s, tmp, pt)) i++;
        else full = 1;
      end
      if (size > rng_hi[i] - rng_lo[i]) continue;
      if (!kind_ok(t, rng_ty[i])) continue;
      res = rng_lo[i];
      rng_lo[i] += size;
      if (rng_lo[i] == rng_hi[i]) rng_erase(i);
      return 1;
    end
    return 0;
  endfunction

  function automatic void merge_ranges();
    for (int i = rng_n; i > 1; i--) begin
      if (rng_ty[i-2] == rng_ty[i-1] && rng_hi[i-2] == rng_lo[i-1]) begin
        rng_hi[i-2] = rng_hi[i-1];
        rng_erase(i - 1);
      end
    end
  endfunction

  function automatic out_t table_step(op_item_t it);
    out_t o;
    bit full;
    int k;
    o = '0;
    o.region_index = RIDX_NONE;
    full = 0;
    case (it.act)
      ACT_ADD: o.table_full = add_range(it.d.region_address, it.d.region_size,
                                        it.d.region_type);
      ACT_REMOVE: o.table_full = remove_range(it.d.region_address, it.d.region_size);
      ACT_ALLOC: begin
        o.ok = first_fit(it.d.region_size, it.d.region_type, it.d.region_address,
                         it.d.alignment, o.result_address, full);
        if (!o.ok && (it.d.region_type & T_DISCARD) != 0 && it.d.region_address == 0)
          o.ok = first_fit(it.d.region_size, it.d.region_type & ~T_DISCARD,
                           it.d.region_address, it.d.alignment, o.result_address, full);
        if (!o.ok) o.result_address = 0;
        o.table_full = full;
      end
      ACT_PACK: merge_ranges();
      ACT_FIND: begin
        k = lookup(it.d.region_address);
        if (k < rng_n) begin
          o.ok = 1;
          o.region_index = RIDX_W'(k);
          o.result_address = rng_lo[k];
          o.region_end = rng_hi[k];
          o.found_type = rng_ty[k];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic queue_op(logic [2:0] act, logic [63:0] addr, logic [63:0] size,
                          logic [7:0] ty, logic [31:0] align);
    op_item_t it;
    it.act = act;
    it.d.region_address = addr;
    it.d.region_size = size;
    it.d.region_type = ty;
    it.d.alignment = align;
    pending_ops.insert(pending_ops.size(), it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return 64'($urandom_range(0, 'h3FFFF));
    if (p < 95) return rand64();
    return ~64'($urandom_range(0, 'h3FFFF));
  endfunction

  function automatic logic [63:0] pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 64'($urandom_range(1, 'h2000));
    if (p < 90) return rand64();
    return 64'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] pick_type();
    logic [7:0] set[8] = '{8'h00, 8'h03, 8'h13, 8'h07, 8'h27, 8'h01, 8'h1B, 8'h3F};
    if ($urandom_range(0, 1) == 0) return set[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_align();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 32'($urandom_range(0, 1));
    if (p < 85) return 32'($urandom_range(2, 'h1000));
    return $urandom;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata <= '0;
      s_tuser <= '0;
      gap_left <= 0;
      burst_left <= 1;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                table_step(op_item_t'{act: s_tuser, d: in_t'(s_tdata)}));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          s_tvalid <= 0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          op_item_t it;
          it = pending_ops.pop_front();
          s_tvalid <= 1;
          s_tuser <= it.act;
          s_tdata <= it.d;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && results_seen == 150) begin
      hold_left <= 3000;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      ready_phase <= 0;
      ready_mode <= 0;
    end else begin
      if (ready_phase == 0) begin
        ready_phase <= $urandom_range(20, 400);
        ready_mode <= $urandom_range(0, 1);
      end else begin
        ready_phase <= ready_phase - 1;
      end
      m_tready <= (hold_left == 0) && (ready_mode || $urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      mismatches <= 0;
      results_seen <= 0;
    end else if (m_tvalid && m_tready) begin
      out_t got;
      out_t want;
      got = out_t'(m_tdata);
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected transaction on result port: %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.ok !== want.ok || got.table_full !== want.table_full ||
            got.result_address !== want.result_address ||
            got.region_index !== want.region_index ||
            got.region_end !== want.region_end || got.found_type !== want.found_type) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("Result %0d mismatch: exp ok=%b full=%b addr=%h idx=%0d end=%h ty=%h",
                     results_seen, want.ok, want.table_full, want.result_address,
                     want.region_index, want.region_end, want.found_type);
            $display("  got ok=%b full=%b addr=%h idx=%0d end=%h ty=%h",
                     got.ok, got.table_full, got.result_address, got.region_index,
                     got.region_end, got.found_type);
          end
        end
      end
    end
  end

  initial begin
    int p;
    queue_op(ACT_ADD, 64'h1000, 64'h1000, 8'h03, 0);
    queue_op(ACT_ADD, 64'h1800, 64'h1000, 8'h07, 0);
    queue_op(ACT_ADD, 64'h0, 64'h0, 8'hFF, 0);
    queue_op(ACT_ADD, 64'h0, 64'h100, 8'h13, 0);
    queue_op(ACT_ADD, 64'hFFFF_FFFF_FFFF_F000, '1, 8'h27, 0);
    queue_op(ACT_FIND, 64'h1800, 0, 0, 0);
    queue_op(ACT_FIND, 64'h8000, 0, 0, 0);
    queue_op(ACT_FIND, '1, 0, 0, 0);
    queue_op(ACT_REMOVE, 64'h1400, 64'h100, 0, 0);
    queue_op(ACT_ALLOC, 0, 64'h10, 8'h00, 1);
    queue_op(ACT_ALLOC, 0, 64'h20, 8'h17, 32'h40);
    queue_op(ACT_ALLOC, 64'h2100, 64'h40, 8'h03, 32'h100);
    queue_op(ACT_ALLOC, 64'hFFFF_FFFF_FFFF_F800, 64'h10, 8'h00, 32'h400);
    queue_op(ACT_ALLOC, 64'hFFFF_FFFF_FFFF_FFF0, 64'h1, 8'h00, '1);
    queue_op(ACT_ALLOC, 0, 64'h10, 8'h00, '1);
    queue_op(ACT_ALLOC, 0, '1, 8'hC0, 0);
    queue_op(ACT_PACK, 0, 0, 0, 0);
    queue_op(ACT_FIND, 64'h1000, 0, 0, 0);
    queue_op(3'd5, rand64(), rand64(), 8'($urandom), $urandom);
    queue_op(3'd6, rand64(), rand64(), 8'($urandom), $urandom);
    queue_op(3'd7, rand64(), rand64(), 8'($urandom), $urandom);
    queue_op(ACT_REMOVE, 0, '1, 0, 0);
    for (int n = 0; n < 550; n++) begin
      if (n % 70 == 69) begin
        queue_op(ACT_REMOVE, 0, '1, 0, 0);
      end else begin
        p = $urandom_range(0, 99);
        if (p < 35)
          queue_op(ACT_ADD, pick_addr(), pick_size(), pick_type(), $urandom);
        else if (p < 50)
          queue_op(ACT_REMOVE, pick_addr(), pick_size(), 8'($urandom), $urandom);
        else if (p < 80)
          queue_op(ACT_ALLOC, ($urandom_range(0, 1) == 0) ? 64'd0 : pick_addr(),
                   pick_size(), pick_type(), pick_align());
        else if (p < 85)
          queue_op(ACT_PACK, rand64(), rand64(), 8'($urandom), $urandom);
        else
          queue_op(ACT_FIND, pick_addr(), rand64(), 8'($urandom), $urandom);
      end
    end
    @(negedge clk);
    while (rst || pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/arta_pkg.sv
sv/arta_rem.sv
sv/address_range_table_allocator_top.sv
sv/arta_chk.sv
bench/tb_address_range_table_allocator_top.sv
